// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define CDH_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("cdh assertion failed");

// Check that a condition implies another at the same edge.
`define CDH_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdh assertion failed");

`endif

// ===== rtl/cdh_pkg.sv =====
package cdh_pkg;

  typedef struct packed {
    logic [15:0] uniform_a;
    logic [15:0] uniform_b;
  } in_t;

  typedef struct packed {
    logic signed [15:0] disk_x;
    logic signed [15:0] disk_y;
    logic [14:0]        hemi_height;
  } out_t;

  typedef enum logic [1:0] {
    WEDGE_POS_X,
    WEDGE_POS_Y,
    WEDGE_NEG_X,
    WEDGE_NEG_Y
  } wedge_t;

  localparam int DIV_CELLS    = 30;
  localparam int HORNER_CELLS = 5;
  localparam int SQRT_CELLS   = 16;
  localparam int PIPE_LATENCY = 1 + DIV_CELLS + 2 + 2 * HORNER_CELLS + 3 + SQRT_CELLS + 1;

  localparam logic [30:0] TRIG_ONE = 31'h4000_0000;
  localparam logic [29:0] PI4_Q30  = 30'd843314857;

  // Reciprocals ceil(2^37 / d): exact floor division for any 30-bit dividend, d < 128
  localparam logic [63:0] RCP_D72 = ((64'd1 << 37) + 64'd71) / 64'd72;
  localparam logic [63:0] RCP_D42 = ((64'd1 << 37) + 64'd41) / 64'd42;
  localparam logic [63:0] RCP_D20 = ((64'd1 << 37) + 64'd19) / 64'd20;
  localparam logic [63:0] RCP_D6  = ((64'd1 << 37) + 64'd5) / 64'd6;
  localparam logic [63:0] RCP_D90 = ((64'd1 << 37) + 64'd89) / 64'd90;
  localparam logic [63:0] RCP_D56 = ((64'd1 << 37) + 64'd55) / 64'd56;
  localparam logic [63:0] RCP_D30 = ((64'd1 << 37) + 64'd29) / 64'd30;
  localparam logic [63:0] RCP_D12 = ((64'd1 << 37) + 64'd11) / 64'd12;
  localparam logic [63:0] RCP_D2  = ((64'd1 << 37) + 64'd1) / 64'd2;

  localparam logic [36:0] SIN_RCP [HORNER_CELLS] = '{
    RCP_D72[36:0], RCP_D42[36:0], RCP_D20[36:0], RCP_D6[36:0], RCP_D2[36:0]};
  localparam logic [36:0] COS_RCP [HORNER_CELLS] = '{
    RCP_D90[36:0], RCP_D56[36:0], RCP_D30[36:0], RCP_D12[36:0], RCP_D2[36:0]};

  typedef struct packed {
    logic        valid;
    logic        origin;
    wedge_t      k;
    logic        sneg;
    logic [16:0] r;
    logic [16:0] rem;
    logic [30:0] quo;
  } div_tok_t;

  typedef struct packed {
    logic        valid;
    logic        origin;
    wedge_t      k;
    logic        sneg;
    logic [16:0] r;
    logic [29:0] a;
    logic [29:0] a2;
    logic [30:0] s;
    logic [30:0] c;
  } trig_tok_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [30:0]        v;
    logic [30:0]        res;
  } sqrt_tok_t;

  function automatic logic [29:0] div_rcp(input logic [29:0] x, input logic [36:0] m);
    logic [66:0] p;
    p = 67'(x) * 67'(m);
    return p[66:37];
  endfunction

endpackage

// ===== rtl/concentric_disk_hemisphere_sampler.sv =====
// channel   ports                      transaction
// input     start, busy, in_data       start high while busy low
// result    out_valid, out_data        one-cycle strobe, always taken
//
// One pair enters every cycle; busy stays low.
// The pipeline holds 30 divider cells for the wedge ratio,
// five two-stage Horner cells for sine and cosine, and 16 square-root cells.
// Synchronous active-low reset clears only the valid bits of the chain.
// The receiver cannot stall, so nothing is ever held back.
module concentric_disk_hemisphere_sampler import cdh_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  // wedge decode
  logic signed [17:0] sx;
  logic signed [17:0] sy;
  logic signed [17:0] r_s;
  logic signed [17:0] num;
  logic signed [17:0] num_abs;
  logic [16:0]        mag;
  logic               ge0;
  div_tok_t           dec_nxt;
  div_tok_t           dec_r;

  always_comb begin
    sx = $signed({1'b0, in_data.uniform_a, 1'b0}) - 18'sd65536;
    sy = $signed({1'b0, in_data.uniform_b, 1'b0}) - 18'sd65536;
    dec_nxt = '0;
    if (sx >= -sy) begin
      if (sx > sy) begin
        dec_nxt.k = WEDGE_POS_X; r_s = sx; num = sy;
      end else begin
        dec_nxt.k = WEDGE_POS_Y; r_s = sy; num = -sx;
      end
    end else begin
      if (sx <= sy) begin
        dec_nxt.k = WEDGE_NEG_X; r_s = -sx; num = -sy;
      end else begin
        dec_nxt.k = WEDGE_NEG_Y; r_s = -sy; num = sx;
      end
    end
    num_abs = num[17] ? -num : num;
    mag     = num_abs[16:0];
    ge0     = mag >= r_s[16:0];
    dec_nxt.valid  = start;
    dec_nxt.origin = (sx == 18'sd0) && (sy == 18'sd0);
    dec_nxt.sneg   = num[17];
    dec_nxt.r      = r_s[16:0];
    dec_nxt.rem    = ge0 ? mag - r_s[16:0] : mag;
    dec_nxt.quo    = {30'd0, ge0};
  end

  // divider chain
  div_tok_t div_tok [DIV_CELLS+1];
  assign div_tok[0] = dec_r;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    cdh_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (div_tok[i]),
      .tok_out (div_tok[i+1])
    );
  end

  // angle and its square
  logic [60:0] prod_a;
  logic [59:0] prod_a2;
  trig_tok_t   ang_nxt;
  trig_tok_t   ang_r;
  trig_tok_t   sq_nxt;
  trig_tok_t   sq_r;

  always_comb begin
    prod_a  = 61'(div_tok[DIV_CELLS].quo) * 61'(PI4_Q30);
    ang_nxt = '0;
    ang_nxt.valid  = div_tok[DIV_CELLS].valid;
    ang_nxt.origin = div_tok[DIV_CELLS].origin;
    ang_nxt.k      = div_tok[DIV_CELLS].k;
    ang_nxt.sneg   = div_tok[DIV_CELLS].sneg;
    ang_nxt.r      = div_tok[DIV_CELLS].r;
    ang_nxt.a      = prod_a[59:30];
    ang_nxt.s      = TRIG_ONE;
    ang_nxt.c      = TRIG_ONE;
  end

  always_comb begin
    prod_a2 = 60'(ang_r.a) * 60'(ang_r.a);
    sq_nxt  = ang_r;
    sq_nxt.a2 = prod_a2[59:30];
  end

  // Horner chain for sine and cosine
  trig_tok_t trig_tok [HORNER_CELLS+1];
  assign trig_tok[0] = sq_r;

  for (genvar i = 0; i < HORNER_CELLS; i++) begin : g_horner
    cdh_horner_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .rcp_s   (SIN_RCP[i]),
      .rcp_c   (COS_RCP[i]),
      .last    (i == HORNER_CELLS - 1),
      .tok_in  (trig_tok[i]),
      .tok_out (trig_tok[i+1])
    );
  end

  // scale by radius, round half up
  trig_tok_t   tt;
  logic [30:0] mx;
  logic [30:0] my;
  logic [47:0] px;
  logic [47:0] py;
  logic [16:0] qx_nxt, qx_r;
  logic [16:0] qy_nxt, qy_r;
  logic        negx_nxt, negx_r;
  logic        negy_nxt, negy_r;
  logic        org_r;
  logic        dv_r;

  always_comb begin
    tt = trig_tok[HORNER_CELLS];
    unique case (tt.k)
      WEDGE_POS_X: begin mx = tt.c; my = tt.s; negx_nxt = 1'b0;     negy_nxt = tt.sneg;  end
      WEDGE_POS_Y: begin mx = tt.s; my = tt.c; negx_nxt = !tt.sneg; negy_nxt = 1'b0;     end
      WEDGE_NEG_X: begin mx = tt.c; my = tt.s; negx_nxt = 1'b1;     negy_nxt = !tt.sneg; end
      default:     begin mx = tt.s; my = tt.c; negx_nxt = tt.sneg;  negy_nxt = 1'b1;     end
    endcase
    px = 48'(tt.r) * 48'(mx) + 48'h4000_0000;
    py = 48'(tt.r) * 48'(my) + 48'h4000_0000;
    qx_nxt = px[47:31];
    qy_nxt = py[47:31];
  end

  // sign and saturation
  logic signed [15:0] x_nxt, x_r;
  logic signed [15:0] y_nxt, y_r;
  logic               xy_v_r;

  always_comb begin
    if (org_r) begin
      x_nxt = '0;
    end else if (negx_r) begin
      x_nxt = (qx_r >= 17'h08000) ? 16'sh8000 : 16'(17'd0 - qx_r);
    end else begin
      x_nxt = (qx_r >= 17'h08000) ? 16'sh7fff : qx_r[15:0];
    end
    if (org_r) begin
      y_nxt = '0;
    end else if (negy_r) begin
      y_nxt = (qy_r >= 17'h08000) ? 16'sh8000 : 16'(17'd0 - qy_r);
    end else begin
      y_nxt = (qy_r >= 17'h08000) ? 16'sh7fff : qy_r[15:0];
    end
  end

  // squared radius and square-root operand
  logic [15:0] ax;
  logic [15:0] ay;
  logic [31:0] total;
  sqrt_tok_t   rad_nxt;
  sqrt_tok_t   rad_r;

  always_comb begin
    ax    = x_r[15] ? 16'(-x_r) : 16'(x_r);
    ay    = y_r[15] ? 16'(-y_r) : 16'(y_r);
    total = 32'(ax) * 32'(ax) + 32'(ay) * 32'(ay);
    rad_nxt.valid = xy_v_r;
    rad_nxt.x     = x_r;
    rad_nxt.y     = y_r;
    rad_nxt.v     = (total < 32'h4000_0000) ? 31'(32'h4000_0000 - total) : '0;
    rad_nxt.res   = '0;
  end

  sqrt_tok_t sqrt_tok [SQRT_CELLS+1];
  assign sqrt_tok[0] = rad_r;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    cdh_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .bit_val (31'(1) << (30 - 2 * i)),
      .tok_in  (sqrt_tok[i]),
      .tok_out (sqrt_tok[i+1])
    );
  end

  out_t out_nxt;
  out_t out_r;
  logic out_valid_r;

  always_comb begin
    out_nxt.disk_x      = sqrt_tok[SQRT_CELLS].x;
    out_nxt.disk_y      = sqrt_tok[SQRT_CELLS].y;
    out_nxt.hemi_height = (sqrt_tok[SQRT_CELLS].res > 31'd32767) ? 15'h7fff
                          : sqrt_tok[SQRT_CELLS].res[14:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r.valid  <= 1'b0;
      ang_r.valid  <= 1'b0;
      sq_r.valid   <= 1'b0;
      dv_r         <= 1'b0;
      xy_v_r       <= 1'b0;
      rad_r.valid  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      dec_r        <= dec_nxt;
      ang_r        <= ang_nxt;
      sq_r         <= sq_nxt;
      dv_r         <= tt.valid;
      xy_v_r       <= dv_r;
      rad_r        <= rad_nxt;
      out_valid_r  <= sqrt_tok[SQRT_CELLS].valid;
    end
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
    negx_r <= negx_nxt;
    negy_r <= negy_nxt;
    org_r  <= tt.origin;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/cdh_div_cell.sv =====
module cdh_div_cell import cdh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_tok_t tok_in,
  output div_tok_t tok_out
);

  logic [17:0] rem2;
  logic        ge;
  div_tok_t    tok_nxt;
  div_tok_t    tok_r;

  // one quotient bit per cell: shift, compare, subtract
  always_comb begin
    rem2    = {tok_in.rem, 1'b0};
    ge      = rem2 >= {1'b0, tok_in.r};
    tok_nxt = tok_in;
    tok_nxt.rem = ge ? 17'(rem2 - {1'b0, tok_in.r}) : rem2[16:0];
    tok_nxt.quo = {tok_in.quo[29:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== rtl/cdh_horner_cell.sv =====
module cdh_horner_cell import cdh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [36:0] rcp_s,
  input  logic [36:0] rcp_c,
  input  logic        last,
  input  trig_tok_t   tok_in,
  output trig_tok_t   tok_out
);

  logic [29:0] ms;
  logic [60:0] prod_s;
  logic [60:0] prod_c;
  trig_tok_t   mid_nxt;
  trig_tok_t   mid_r;
  trig_tok_t   tok_nxt;
  trig_tok_t   tok_r;

  // the last cell closes the sine with a final multiply by a
  always_comb begin
    ms      = last ? tok_in.a : tok_in.a2;
    prod_s  = 61'(ms) * 61'(tok_in.s);
    prod_c  = 61'(tok_in.a2) * 61'(tok_in.c);
    mid_nxt = tok_in;
    mid_nxt.s = {1'b0, prod_s[59:30]};
    mid_nxt.c = {1'b0, prod_c[59:30]};
  end

  always_comb begin
    tok_nxt = mid_r;
    tok_nxt.s = last ? mid_r.s : TRIG_ONE - {1'b0, div_rcp(mid_r.s[29:0], rcp_s)};
    tok_nxt.c = TRIG_ONE - {1'b0, div_rcp(mid_r.c[29:0], rcp_c)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r.valid <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      mid_r <= mid_nxt;
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== rtl/cdh_sqrt_cell.sv =====
module cdh_sqrt_cell import cdh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [30:0] bit_val,
  input  sqrt_tok_t   tok_in,
  output sqrt_tok_t   tok_out
);

  logic [31:0] sum;
  logic        ge;
  sqrt_tok_t   tok_nxt;
  sqrt_tok_t   tok_r;

  always_comb begin
    sum     = {1'b0, tok_in.res} + {1'b0, bit_val};
    ge      = {1'b0, tok_in.v} >= sum;
    tok_nxt = tok_in;
    tok_nxt.v   = ge ? 31'({1'b0, tok_in.v} - sum) : tok_in.v;
    tok_nxt.res = ge ? (tok_in.res >> 1) + bit_val : tok_in.res >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== rtl/cdh_checker.sv =====
`include "assert_macros.svh"

module cdh_checker import cdh_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  logic [6:0] settle_r;
  logic [6:0] settle_nxt;
  logic       settled;

  // count cycles since reset so that history before it is ignored
  assign settle_nxt = (settle_r == 7'(PIPE_LATENCY)) ? settle_r : settle_r + 7'd1;
  assign settled    = settle_r == 7'(PIPE_LATENCY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= '0;
    end else begin
      settle_r <= settle_nxt;
    end
  end

  `CDH_ASSERT_ALWAYS(a_never_busy, clk, rst_n, busy == 1'b0)
  `CDH_ASSERT_IMPLIES(a_strobe_latency, clk, rst_n, settled, out_valid == $past(start && !busy, PIPE_LATENCY))
  `CDH_ASSERT_IMPLIES(a_origin_height, clk, rst_n, out_valid && out_data.disk_x == 16'sd0 && out_data.disk_y == 16'sd0, out_data.hemi_height == 15'h7fff)
  `CDH_ASSERT_IMPLIES(a_centre_in, clk, rst_n, settled && out_valid && $past(in_data.uniform_a, PIPE_LATENCY) == 16'h8000 && $past(in_data.uniform_b, PIPE_LATENCY) == 16'h8000, out_data.disk_x == 16'sd0 && out_data.disk_y == 16'sd0)

endmodule

bind concentric_disk_hemisphere_sampler cdh_checker u_cdh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
